@@ sv/rcsr_pkg.sv @@
// ----------------------------------------------------------------------------
// rcsr_pkg
// Shared types, constants and address decode for the CSR file with timer.
// ----------------------------------------------------------------------------
package rcsr_pkg;

    localparam int PmpCfgCountDef  = 16;
    localparam int PmpAddrCountDef = 64;

    localparam logic [31:0] SstatusView   = 32'h800D_E762;
    localparam logic [31:0] EpcMask       = 32'hFFFF_FFFC;
    localparam logic [31:0] IeMask        = 32'h0000_0AAA;
    localparam logic [31:0] IpWriteMask   = 32'h0000_0222;
    localparam logic [31:0] TvecReset     = 32'h0000_0005;
    localparam logic [15:0] EdelegReset   = 16'hB3FF;
    localparam int          TimerBit      = 7;

    localparam logic [1:0] ModeRead  = 2'd0;
    localparam logic [1:0] ModeWrite = 2'd1;
    localparam logic [1:0] ModeTick  = 2'd2;

    // Input item
    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] address;
        logic [31:0] write_data;
        logic [1:0]  privilege;
        logic        checked;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [31:0] read_data;
        logic        illegal;
        logic        timer_pending;
    } t_out_item;

    // Register selects produced by the address decoder
    typedef enum logic [5:0] {
        R_NONE, R_ZERO, R_ZERO_RO, R_PMPCFG, R_PMPADDR,
        R_SSTATUS, R_SIE, R_STVEC, R_SCOUNTEREN, R_SENVCFG, R_SSCRATCH, R_SEPC,
        R_SCAUSE, R_SIP, R_SATP,
        R_MSTATUS, R_MEDELEG, R_MIDELEG, R_MIE, R_MTVEC, R_MENVCFG, R_MSCRATCH,
        R_MEPC, R_MCAUSE, R_MIP,
        R_MCYCLE, R_MINSTRET, R_MCYCLEH, R_MINSTRETH,
        R_CYCLE_RO, R_INSTRET_RO, R_CYCLEH_RO, R_INSTRETH_RO,
        R_MTIME, R_MTIMEH, R_TIME_RO, R_TIMEH_RO, R_MTIMECMP, R_MTIMECMPH
    } t_sel;

    // Decoded access, passed from the decoder to the register bank
    typedef struct packed {
        t_sel        sel;
        logic        rd_en;
        logic        wr_en;
        logic        tick;
        logic        bad;
        logic [5:0]  idx;
        logic [31:0] data;
    } t_dec;

    function automatic t_sel decode_addr(input logic [11:0] a);
        t_sel s;
        s = R_NONE;
        if ((a >= 12'h323 && a <= 12'h33F) || (a >= 12'hB03 && a <= 12'hB1F) ||
            (a >= 12'hB83 && a <= 12'hB9F)) begin
            s = R_ZERO;
        end else if ((a >= 12'hC03 && a <= 12'hC1F) || (a >= 12'hC83 && a <= 12'hC9F)) begin
            s = R_ZERO_RO;
        end else if (a >= 12'h3A0 && a <= 12'h3AF) begin
            s = R_PMPCFG;
        end else if (a >= 12'h3B0 && a <= 12'h3EF) begin
            s = R_PMPADDR;
        end else begin
            case (a)
                12'h100: s = R_SSTATUS;
                12'h104: s = R_SIE;
                12'h105: s = R_STVEC;
                12'h106: s = R_SCOUNTEREN;
                12'h10A: s = R_SENVCFG;
                12'h140: s = R_SSCRATCH;
                12'h141: s = R_SEPC;
                12'h142: s = R_SCAUSE;
                12'h144: s = R_SIP;
                12'h180: s = R_SATP;
                12'h300: s = R_MSTATUS;
                12'h302: s = R_MEDELEG;
                12'h303: s = R_MIDELEG;
                12'h304: s = R_MIE;
                12'h305: s = R_MTVEC;
                12'h30A: s = R_MENVCFG;
                12'h340: s = R_MSCRATCH;
                12'h341: s = R_MEPC;
                12'h342: s = R_MCAUSE;
                12'h344: s = R_MIP;
                12'hB00: s = R_MCYCLE;
                12'hB02: s = R_MINSTRET;
                12'hB80: s = R_MCYCLEH;
                12'hB82: s = R_MINSTRETH;
                12'hC00: s = R_CYCLE_RO;
                12'hC02: s = R_INSTRET_RO;
                12'hC80: s = R_CYCLEH_RO;
                12'hC82: s = R_INSTRETH_RO;
                12'h7C0: s = R_MTIME;
                12'h7C1: s = R_MTIMEH;
                12'hC01: s = R_TIME_RO;
                12'hC81: s = R_TIMEH_RO;
                12'h7C2: s = R_MTIMECMP;
                12'h7C3: s = R_MTIMECMPH;
                12'h143, 12'h301, 12'h310, 12'h31A, 12'h320, 12'h343: s = R_ZERO;
                12'h306, 12'hF11, 12'hF12, 12'hF13, 12'hF14, 12'hF15: s = R_ZERO_RO;
                default: s = R_NONE;
            endcase
        end
        return s;
    endfunction

endpackage

@@ sv/rcsr_decode.sv @@
// ----------------------------------------------------------------------------
// rcsr_decode
// Registers the input item and decodes address, privilege and legality.
// ----------------------------------------------------------------------------
module rcsr_decode
    import rcsr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_item,
    output logic     o_valid,
    output t_dec     o_dec
);

    logic     r_valid;
    t_in_item r_item;
    t_sel     sel;
    logic     ro_sel;
    logic     priv_low;
    logic     is_rd;
    logic     is_wr;
    logic     refused;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_start;
        end
        if (i_start) begin
            r_item <= i_item;
        end
    end

    // Decode and checks
    always_comb begin
        sel      = decode_addr(r_item.address);
        priv_low = r_item.privilege < r_item.address[9:8];
        is_rd    = r_item.mode == ModeRead;
        is_wr    = r_item.mode == ModeWrite;
        ro_sel   = sel inside {R_ZERO_RO, R_CYCLE_RO, R_INSTRET_RO, R_CYCLEH_RO,
                               R_INSTRETH_RO, R_TIME_RO, R_TIMEH_RO};
        refused  = 1'b0;
        if (is_rd) begin
            refused = (r_item.checked && priv_low) || sel == R_NONE;
        end else if (is_wr) begin
            refused = (r_item.checked && (r_item.address[11:10] == 2'b11 || priv_low))
                      || sel == R_NONE || ro_sel;
        end
        o_dec.sel   = sel;
        o_dec.bad   = refused;
        o_dec.rd_en = is_rd && !refused;
        o_dec.wr_en = is_wr && !refused;
        o_dec.tick  = r_item.mode == ModeTick;
        o_dec.idx   = r_item.address[11:4] == 8'h3A ? {2'b00, r_item.address[3:0]}
                                                    : 6'(r_item.address - 12'h3B0);
        o_dec.data  = r_item.write_data;
    end

    assign o_valid = r_valid;

endmodule

@@ sv/rcsr_regs.sv @@
// ----------------------------------------------------------------------------
// rcsr_regs
// Register bank, counters, timer and result register.
// ----------------------------------------------------------------------------
module rcsr_regs
    import rcsr_pkg::*;
#(
    parameter int PMP_CFG_COUNT  = PmpCfgCountDef,
    parameter int PMP_ADDR_COUNT = PmpAddrCountDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_dec        i_dec,
    input  logic [15:0] i_edeleg_mask,
    output logic        o_strobe,
    output t_out_item   o_item
);

    localparam int CfgW  = PMP_CFG_COUNT > 1 ? $clog2(PMP_CFG_COUNT) : 1;
    localparam int AddrW = PMP_ADDR_COUNT > 1 ? $clog2(PMP_ADDR_COUNT) : 1;

    logic [31:0] r_mstatus;
    logic [31:0] r_s [8];
    logic        r_senv;
    logic [31:0] r_m [8];
    logic        r_menv;
    logic        r_mtip;
    logic [31:0] r_pmpcfg [PMP_CFG_COUNT];
    logic [31:0] r_pmpaddr [PMP_ADDR_COUNT];
    logic [31:0] r_pmpaddr_q;
    logic        r_pmpaddr_hit;
    logic [63:0] r_mcycle;
    logic [63:0] r_minstret;
    logic [63:0] r_mtime;
    logic [63:0] r_mtimecmp;
    logic        r_strobe;
    t_out_item   r_out;

    logic [63:0] time_now;
    logic        time_hit;
    logic        n_mtip;
    logic [31:0] rd;
    logic [31:0] d;
    logic        cfg_in;
    logic        addr_in;

    assign d       = i_dec.data;
    assign cfg_in  = 32'(i_dec.idx) < PMP_CFG_COUNT;
    assign addr_in = 32'(i_dec.idx) < PMP_ADDR_COUNT;
    assign time_now = (i_valid && i_dec.tick) ? r_mtime + 64'd1 : r_mtime;
    assign time_hit = time_now >= r_mtimecmp;

    // Read mux and timer-pending update
    always_comb begin
        rd     = '0;
        n_mtip = r_mtip;
        if (i_valid && i_dec.tick && time_hit) begin
            n_mtip = 1'b1;
        end
        if (i_valid && i_dec.rd_en) begin
            case (i_dec.sel)
                R_PMPCFG:  rd = cfg_in ? r_pmpcfg[i_dec.idx[CfgW-1:0]] : '0;
                // The PMP address store is read through its own output register.
                R_PMPADDR: rd = '0;
                R_SSTATUS: rd = r_mstatus & SstatusView;
                R_SIE:        rd = r_s[0];
                R_STVEC:      rd = r_s[1];
                R_SCOUNTEREN: rd = r_s[2];
                R_SENVCFG:    rd = {31'd0, r_senv};
                R_SSCRATCH:   rd = r_s[3];
                R_SEPC:       rd = r_s[4];
                R_SCAUSE:     rd = r_s[5];
                R_SIP:        rd = r_s[6];
                R_SATP:       rd = r_s[7];
                R_MSTATUS:    rd = r_mstatus;
                R_MEDELEG:    rd = r_m[0];
                R_MIDELEG:    rd = r_m[1];
                R_MIE:        rd = r_m[2];
                R_MTVEC:      rd = r_m[3];
                R_MENVCFG:    rd = {31'd0, r_menv};
                R_MSCRATCH:   rd = r_m[4];
                R_MEPC:       rd = r_m[5];
                R_MCAUSE:     rd = r_m[6];
                R_MIP:        rd = r_m[7] | (32'(r_mtip) << TimerBit);
                R_MCYCLE, R_CYCLE_RO:       rd = r_mcycle[31:0];
                R_MINSTRET, R_INSTRET_RO:   rd = r_minstret[31:0];
                R_MCYCLEH, R_CYCLEH_RO:     rd = r_mcycle[63:32];
                R_MINSTRETH, R_INSTRETH_RO: rd = r_minstret[63:32];
                R_MTIME, R_TIME_RO: begin
                    rd = r_mtime[31:0];
                    if (time_hit) n_mtip = 1'b1;
                end
                R_MTIMEH, R_TIMEH_RO: begin
                    rd = r_mtime[63:32];
                    if (time_hit) n_mtip = 1'b1;
                end
                R_MTIMECMP:  rd = r_mtimecmp[31:0];
                R_MTIMECMPH: rd = r_mtimecmp[63:32];
                default:     rd = '0;
            endcase
        end
        if (i_valid && i_dec.wr_en &&
            (i_dec.sel == R_MTIMECMP || i_dec.sel == R_MTIMECMPH)) begin
            n_mtip = 1'b0;
        end
    end

    // Control state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe   <= 1'b0;
            r_mtip     <= 1'b0;
            r_mstatus  <= '0;
            r_senv     <= 1'b0;
            r_menv     <= 1'b0;
            r_mcycle   <= '0;
            r_minstret <= '0;
            r_mtime    <= '0;
            r_mtimecmp <= '1;
            for (int k = 0; k < 8; k++) begin
                r_s[k] <= '0;
                r_m[k] <= (k == 3) ? TvecReset : '0;
            end
            for (int k = 0; k < PMP_CFG_COUNT; k++) r_pmpcfg[k] <= '0;
        end else begin
            r_strobe <= i_valid;
            r_mtip   <= n_mtip;
            if (i_valid && i_dec.tick) r_mtime <= time_now;
            if (i_valid && i_dec.wr_en) begin
                case (i_dec.sel)
                    R_PMPCFG: if (cfg_in) r_pmpcfg[i_dec.idx[CfgW-1:0]] <= d;
                    R_SSTATUS: r_mstatus <= (r_mstatus & ~SstatusView) | (d & SstatusView);
                    R_SIE:        r_s[0] <= d;
                    R_STVEC:      r_s[1] <= d;
                    R_SCOUNTEREN: r_s[2] <= d;
                    R_SENVCFG:    r_senv <= d[0];
                    R_SSCRATCH:   r_s[3] <= d;
                    R_SEPC:       r_s[4] <= d & EpcMask;
                    R_SCAUSE:     r_s[5] <= d;
                    R_SIP:        r_s[6] <= d;
                    R_SATP:       r_s[7] <= d;
                    R_MSTATUS:    r_mstatus <= d;
                    R_MEDELEG:    r_m[0] <= {16'd0, d[15:0] & i_edeleg_mask};
                    R_MIDELEG:    r_m[1] <= d & IeMask;
                    R_MIE:        r_m[2] <= d & IeMask;
                    R_MTVEC:      r_m[3] <= d;
                    R_MENVCFG:    r_menv <= d[0];
                    R_MSCRATCH:   r_m[4] <= d;
                    R_MEPC:       r_m[5] <= d & EpcMask;
                    R_MCAUSE:     r_m[6] <= d;
                    R_MIP:        r_m[7] <= d & IpWriteMask;
                    R_MCYCLE:     r_mcycle[31:0]    <= d;
                    R_MINSTRET:   r_minstret[31:0]  <= d;
                    R_MCYCLEH:    r_mcycle[63:32]   <= d;
                    R_MINSTRETH:  r_minstret[63:32] <= d;
                    R_MTIME:      r_mtime[31:0]     <= d;
                    R_MTIMEH:     r_mtime[63:32]    <= d;
                    R_MTIMECMP:   r_mtimecmp[31:0]  <= d;
                    R_MTIMECMPH:  r_mtimecmp[63:32] <= d;
                    default: ;
                endcase
            end
        end
    end

    // PMP address store has no reset; it is read into its own output register
    // in the same cycle as the result register is loaded.
    always_ff @(posedge i_clk) begin
        if (i_valid && i_dec.wr_en && i_dec.sel == R_PMPADDR && addr_in) begin
            r_pmpaddr[i_dec.idx[AddrW-1:0]] <= d;
        end
        r_pmpaddr_q <= r_pmpaddr[i_dec.idx[AddrW-1:0]];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        r_out.read_data     <= rd;
        r_out.illegal       <= i_valid && i_dec.bad;
        r_out.timer_pending <= n_mtip;
        r_pmpaddr_hit       <= i_valid && i_dec.rd_en && i_dec.sel == R_PMPADDR && addr_in;
    end

    assign o_strobe = r_strobe;

    // The PMP address read data replaces the zero left in the result register.
    always_comb begin
        o_item = r_out;
        if (r_pmpaddr_hit) begin
            o_item.read_data = r_pmpaddr_q;
        end
    end

    // Checks
    a_illegal_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_out.illegal |-> r_out.read_data == '0) else $error("illegal with data");
    a_cmp_write_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_dec.wr_en && i_dec.sel == R_MTIMECMP |=> !r_mtip)
        else $error("mtimecmp write left MTIP");
    a_tick_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_dec.tick |=> r_mtime == $past(r_mtime) + 64'd1)
        else $error("tick did not advance mtime");

endmodule

@@ sv/riscv_csr_file_with_timer_top.sv @@
// ----------------------------------------------------------------------------
// riscv_csr_file_with_timer_top
// RV32 CSR file with machine timer, one access per clock.
// ----------------------------------------------------------------------------
// An item is taken at every clock edge where start is high; busy is never
// raised. Its result is shown for exactly one cycle with o_strobe high,
// after passing the input register and decoder, then the register bank and
// result register. The receiver cannot stall the block, so it must take every
// result on the cycle it is shown.
module riscv_csr_file_with_timer_top
    import rcsr_pkg::*;
#(
    parameter int PMP_CFG_COUNT  = PmpCfgCountDef,
    parameter int PMP_ADDR_COUNT = PmpAddrCountDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_strobe,
    output t_out_item   o_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic        dec_valid;
    t_dec        dec;
    logic [15:0] r_edeleg_mask;

    // Delegation mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edeleg_mask <= EdelegReset;
        end else if (i_cfg_valid) begin
            r_edeleg_mask <= i_cfg_data;
        end
    end

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    rcsr_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .o_valid (dec_valid),
        .o_dec   (dec)
    );

    rcsr_regs #(
        .PMP_CFG_COUNT  (PMP_CFG_COUNT),
        .PMP_ADDR_COUNT (PMP_ADDR_COUNT)
    ) u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (dec_valid),
        .i_dec         (dec),
        .i_edeleg_mask (r_edeleg_mask),
        .o_strobe      (o_strobe),
        .o_item        (o_item)
    );

endmodule

@@ tb/rcsr_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// rcsr_tb_pkg
// CSR addresses and address windows shared by the testbench checker and the
// stimulus generator.
// ----------------------------------------------------------------------------
package rcsr_tb_pkg;

    // Supervisor registers
    localparam logic [11:0] CsrSstatus    = 12'h100;
    localparam logic [11:0] CsrSie        = 12'h104;
    localparam logic [11:0] CsrStvec      = 12'h105;
    localparam logic [11:0] CsrScounteren = 12'h106;
    localparam logic [11:0] CsrSenvcfg    = 12'h10A;
    localparam logic [11:0] CsrSscratch   = 12'h140;
    localparam logic [11:0] CsrSepc       = 12'h141;
    localparam logic [11:0] CsrScause     = 12'h142;
    localparam logic [11:0] CsrStval      = 12'h143;
    localparam logic [11:0] CsrSip        = 12'h144;
    localparam logic [11:0] CsrSatp       = 12'h180;

    // Machine registers
    localparam logic [11:0] CsrMstatus       = 12'h300;
    localparam logic [11:0] CsrMisa          = 12'h301;
    localparam logic [11:0] CsrMedeleg       = 12'h302;
    localparam logic [11:0] CsrMideleg       = 12'h303;
    localparam logic [11:0] CsrMie           = 12'h304;
    localparam logic [11:0] CsrMtvec         = 12'h305;
    localparam logic [11:0] CsrMcounteren    = 12'h306;
    localparam logic [11:0] CsrMenvcfg       = 12'h30A;
    localparam logic [11:0] CsrMstatush      = 12'h310;
    localparam logic [11:0] CsrMenvcfgh      = 12'h31A;
    localparam logic [11:0] CsrMcountinhibit = 12'h320;
    localparam logic [11:0] CsrMscratch      = 12'h340;
    localparam logic [11:0] CsrMepc          = 12'h341;
    localparam logic [11:0] CsrMcause        = 12'h342;
    localparam logic [11:0] CsrMtval         = 12'h343;
    localparam logic [11:0] CsrMip           = 12'h344;
    localparam logic [11:0] CsrMvendorid     = 12'hF11;
    localparam logic [11:0] CsrMarchid       = 12'hF12;
    localparam logic [11:0] CsrMimpid        = 12'hF13;
    localparam logic [11:0] CsrMhartid       = 12'hF14;
    localparam logic [11:0] CsrMconfigptr    = 12'hF15;

    // Protection arrays
    localparam logic [11:0] CsrPmpCfgFirst  = 12'h3A0;
    localparam logic [11:0] CsrPmpCfgLast   = 12'h3AF;
    localparam logic [11:0] CsrPmpAddrFirst = 12'h3B0;
    localparam logic [11:0] CsrPmpAddrLast  = 12'h3EF;

    // Counters and timer
    localparam logic [11:0] CsrMcycle    = 12'hB00;
    localparam logic [11:0] CsrMinstret  = 12'hB02;
    localparam logic [11:0] CsrMcycleh   = 12'hB80;
    localparam logic [11:0] CsrMinstreth = 12'hB82;
    localparam logic [11:0] CsrCycle     = 12'hC00;
    localparam logic [11:0] CsrTime      = 12'hC01;
    localparam logic [11:0] CsrInstret   = 12'hC02;
    localparam logic [11:0] CsrCycleh    = 12'hC80;
    localparam logic [11:0] CsrTimeh     = 12'hC81;
    localparam logic [11:0] CsrInstreth  = 12'hC82;
    localparam logic [11:0] CsrMtime     = 12'h7C0;
    localparam logic [11:0] CsrMtimeh    = 12'h7C1;
    localparam logic [11:0] CsrMtimecmp  = 12'h7C2;
    localparam logic [11:0] CsrMtimecmph = 12'h7C3;

    // Read-as-zero windows
    localparam logic [11:0] CsrHpmEventFirst = 12'h323;
    localparam logic [11:0] CsrHpmEventLast  = 12'h33F;
    localparam logic [11:0] CsrMhpmFirst     = 12'hB03;
    localparam logic [11:0] CsrMhpmLast      = 12'hB1F;
    localparam logic [11:0] CsrMhpmhFirst    = 12'hB83;
    localparam logic [11:0] CsrMhpmhLast     = 12'hB9F;
    localparam logic [11:0] CsrHpmFirst      = 12'hC03;
    localparam logic [11:0] CsrHpmLast       = 12'hC1F;
    localparam logic [11:0] CsrHpmhFirst     = 12'hC83;
    localparam logic [11:0] CsrHpmhLast      = 12'hC9F;

    // Unused mode value, which must do nothing
    localparam logic [1:0] ModeNone = 2'd3;

endpackage

@@ tb/csr_file_checker.sv @@
// ----------------------------------------------------------------------------
// csr_file_checker
// Watches the item, result and configuration channels of the CSR file,
// predicts each result from its own copy of the register state and compares
// it field by field with what the block produces.
// ----------------------------------------------------------------------------
module csr_file_checker
    import rcsr_pkg::*;
    import rcsr_tb_pkg::*;
#(
    parameter int PMP_CFG_COUNT  = PmpCfgCountDef,
    parameter int PMP_ADDR_COUNT = PmpAddrCountDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_in_item    i_item,
    input  logic        i_strobe,
    input  t_out_item   i_result,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    // Shadow register state
    logic [15:0] edeleg_mask;
    logic [31:0] mstatus;
    logic [31:0] sie, stvec, scounteren, sscratch, sepc, scause, sip, satp;
    logic        senvcfg, menvcfg;
    logic [31:0] medeleg, mideleg, mie, mtvec, mscratch, mepc, mcause, mip;
    logic [31:0] pmp_cfg [PMP_CFG_COUNT];
    logic [31:0] pmp_addr [PMP_ADDR_COUNT];
    logic [63:0] mcycle, minstret, mtime, mtimecmp;

    t_out_item   expected_results [$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    function automatic logic in_window(input logic [11:0] a, input logic [11:0] lo,
                                       input logic [11:0] hi);
        return a >= lo && a <= hi;
    endfunction

    function automatic logic zero_window(input logic [11:0] a);
        return in_window(a, CsrHpmEventFirst, CsrHpmEventLast) ||
               in_window(a, CsrMhpmFirst, CsrMhpmLast) ||
               in_window(a, CsrMhpmhFirst, CsrMhpmhLast);
    endfunction

    // The timer interrupt becomes pending once mtime reaches mtimecmp.
    function automatic void update_timer_pending();
        if (mtime >= mtimecmp) begin
            mip[TimerBit] = 1'b1;
        end
    endfunction

    // Returns 0 for an unknown address.
    function automatic logic read_csr(input logic [11:0] a, output logic [31:0] v);
        int idx;
        v = '0;
        if (zero_window(a) || in_window(a, CsrHpmFirst, CsrHpmLast) ||
            in_window(a, CsrHpmhFirst, CsrHpmhLast)) begin
            return 1'b1;
        end
        if (in_window(a, CsrPmpCfgFirst, CsrPmpCfgLast)) begin
            idx = int'(a - CsrPmpCfgFirst);
            if (idx < PMP_CFG_COUNT) v = pmp_cfg[idx];
            return 1'b1;
        end
        if (in_window(a, CsrPmpAddrFirst, CsrPmpAddrLast)) begin
            idx = int'(a - CsrPmpAddrFirst);
            if (idx < PMP_ADDR_COUNT) v = pmp_addr[idx];
            return 1'b1;
        end
        case (a)
            CsrSstatus:    v = mstatus & SstatusView;
            CsrSie:        v = sie;
            CsrStvec:      v = stvec;
            CsrScounteren: v = scounteren;
            CsrSenvcfg:    v = {31'd0, senvcfg};
            CsrSscratch:   v = sscratch;
            CsrSepc:       v = sepc;
            CsrScause:     v = scause;
            CsrSip:        v = sip;
            CsrSatp:       v = satp;
            CsrMstatus:    v = mstatus;
            CsrMedeleg:    v = medeleg;
            CsrMideleg:    v = mideleg;
            CsrMie:        v = mie;
            CsrMtvec:      v = mtvec;
            CsrMenvcfg:    v = {31'd0, menvcfg};
            CsrMscratch:   v = mscratch;
            CsrMepc:       v = mepc;
            CsrMcause:     v = mcause;
            CsrMip:        v = mip;
            CsrMcycle, CsrCycle:       v = mcycle[31:0];
            CsrMinstret, CsrInstret:   v = minstret[31:0];
            CsrMcycleh, CsrCycleh:     v = mcycle[63:32];
            CsrMinstreth, CsrInstreth: v = minstret[63:32];
            CsrMtime, CsrTime: begin
                update_timer_pending();
                v = mtime[31:0];
            end
            CsrMtimeh, CsrTimeh: begin
                update_timer_pending();
                v = mtime[63:32];
            end
            CsrMtimecmp:  v = mtimecmp[31:0];
            CsrMtimecmph: v = mtimecmp[63:32];
            CsrStval, CsrMisa, CsrMcounteren, CsrMstatush, CsrMenvcfgh,
            CsrMcountinhibit, CsrMtval, CsrMvendorid, CsrMarchid, CsrMimpid,
            CsrMhartid, CsrMconfigptr: v = '0;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Returns 0 where a write is not allowed at all.
    function automatic logic write_csr(input logic [11:0] a, input logic [31:0] d);
        int idx;
        if (zero_window(a)) return 1'b1;
        if (in_window(a, CsrPmpCfgFirst, CsrPmpCfgLast)) begin
            idx = int'(a - CsrPmpCfgFirst);
            if (idx < PMP_CFG_COUNT) pmp_cfg[idx] = d;
            return 1'b1;
        end
        if (in_window(a, CsrPmpAddrFirst, CsrPmpAddrLast)) begin
            idx = int'(a - CsrPmpAddrFirst);
            if (idx < PMP_ADDR_COUNT) pmp_addr[idx] = d;
            return 1'b1;
        end
        case (a)
            CsrSstatus:    mstatus = (mstatus & ~SstatusView) | (d & SstatusView);
            CsrSie:        sie = d;
            CsrStvec:      stvec = d;
            CsrScounteren: scounteren = d;
            CsrSenvcfg:    senvcfg = d[0];
            CsrSscratch:   sscratch = d;
            CsrSepc:       sepc = d & EpcMask;
            CsrScause:     scause = d;
            CsrSip:        sip = d;
            CsrSatp:       satp = d;
            CsrMstatus:    mstatus = d;
            CsrMedeleg:    medeleg = d & {16'd0, edeleg_mask};
            CsrMideleg:    mideleg = d & IeMask;
            CsrMie:        mie = d & IeMask;
            CsrMtvec:      mtvec = d;
            CsrMenvcfg:    menvcfg = d[0];
            CsrMscratch:   mscratch = d;
            CsrMepc:       mepc = d & EpcMask;
            CsrMcause:     mcause = d;
            // The timer pending bit cannot be written through mip.
            CsrMip: mip = (d & IpWriteMask) | (mip & (32'd1 << TimerBit));
            CsrMcycle:    mcycle[31:0] = d;
            CsrMinstret:  minstret[31:0] = d;
            CsrMcycleh:   mcycle[63:32] = d;
            CsrMinstreth: minstret[63:32] = d;
            CsrMtime:     mtime[31:0] = d;
            CsrMtimeh:    mtime[63:32] = d;
            CsrMtimecmp: begin
                mtimecmp[31:0] = d;
                mip[TimerBit] = 1'b0;
            end
            CsrMtimecmph: begin
                mtimecmp[63:32] = d;
                mip[TimerBit] = 1'b0;
            end
            CsrStval, CsrMisa, CsrMstatush, CsrMenvcfgh, CsrMcountinhibit,
            CsrMtval: ;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Applies one access to the shadow state and works out its result.
    function automatic t_out_item predict_csr_access(input t_in_item it);
        t_out_item   res;
        logic [1:0]  need;
        logic [31:0] rd;
        logic        bad;
        need = it.address[9:8];
        rd   = '0;
        bad  = 1'b0;
        case (it.mode)
            ModeRead: begin
                if (it.checked && it.privilege < need) bad = 1'b1;
                else if (!read_csr(it.address, rd)) bad = 1'b1;
            end
            ModeWrite: begin
                if (it.checked && (it.address[11:10] == 2'b11 || it.privilege < need))
                    bad = 1'b1;
                else if (!write_csr(it.address, it.write_data)) bad = 1'b1;
            end
            ModeTick: begin
                mtime = mtime + 64'd1;
                update_timer_pending();
            end
            default: ;
        endcase
        res.read_data     = bad ? 32'd0 : rd;
        res.illegal       = bad;
        res.timer_pending = mip[TimerBit];
        return res;
    endfunction

    // Prediction on accepted items, comparison on strobed results.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            edeleg_mask = EdelegReset;
            mstatus = '0;
            sie = '0; stvec = '0; scounteren = '0; sscratch = '0;
            sepc = '0; scause = '0; sip = '0; satp = '0;
            senvcfg = 1'b0; menvcfg = 1'b0;
            medeleg = '0; mideleg = '0; mie = '0; mtvec = TvecReset;
            mscratch = '0; mepc = '0; mcause = '0; mip = '0;
            for (int i = 0; i < PMP_CFG_COUNT; i++) pmp_cfg[i] = '0;
            for (int i = 0; i < PMP_ADDR_COUNT; i++) pmp_addr[i] = '0;
            mcycle = '0; minstret = '0; mtime = '0; mtimecmp = '1;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result with nothing expected: data %h illegal %b pending %b",
                                 i_result.read_data, i_result.illegal,
                                 i_result.timer_pending);
                end else begin
                    want = expected_results.pop_front();
                    if (want !== i_result) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: data %h/%h illegal %b/%b pending %b/%b %s",
                                     want.read_data, i_result.read_data, want.illegal,
                                     i_result.illegal, want.timer_pending,
                                     i_result.timer_pending, "(expected/actual)");
                    end
                end
            end
            if (i_start && !i_busy) expected_results.push_back(predict_csr_access(i_item));
            if (i_cfg_valid && i_cfg_ready) edeleg_mask = i_cfg_data;
        end
    end

endmodule

@@ tb/riscv_csr_file_with_timer_top_tb.sv @@
// ----------------------------------------------------------------------------
// riscv_csr_file_with_timer_top_tb
// Drives the CSR file with a directed sequence and then random reads, writes
// and timer ticks over several delegation mask settings, mostly with random
// gaps; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module riscv_csr_file_with_timer_top_tb;
    import rcsr_pkg::*;
    import rcsr_tb_pkg::*;

    localparam int CycleLimit = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_item    i_item;
    logic        o_strobe;
    t_out_item   o_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          cycle_count;
    logic        gaps_on;
    logic [63:0] pmp_addr_written;

    logic [11:0] addr_pool [0:29] = '{
        CsrSstatus, CsrSie, CsrSepc, CsrSip, CsrSenvcfg, CsrSatp, CsrMstatus,
        CsrMedeleg, CsrMideleg, CsrMie, CsrMtvec, CsrMenvcfg, CsrMepc, CsrMip,
        CsrMcounteren, CsrPmpCfgFirst, CsrPmpCfgLast, CsrPmpAddrFirst,
        CsrPmpAddrLast, CsrMcycle, CsrMinstreth, CsrCycle, CsrInstreth,
        CsrMtime, CsrMtimeh, CsrTime, CsrTimeh, CsrMtimecmp, CsrMtimecmph,
        CsrMhartid
    };

    riscv_csr_file_with_timer_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    csr_file_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_in_item make_access(input logic [1:0] mode, input logic [11:0] a,
                                             input logic [31:0] d, input logic [1:0] priv,
                                             input logic chk);
        t_in_item it;
        it.mode = mode;
        it.address = a;
        it.write_data = d;
        it.privilege = priv;
        it.checked = chk;
        return it;
    endfunction

    // A random access, mostly to implemented registers.
    function automatic t_in_item random_access();
        t_in_item it;
        int       r;
        r = $urandom_range(0, 99);
        it.mode = (r < 45) ? ModeRead : (r < 85) ? ModeWrite : (r < 97) ? ModeTick : ModeNone;
        it.address = ($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, 29)]
                                                 : 12'($urandom);
        if ($urandom_range(0, 5) == 0)
            it.address = CsrPmpAddrFirst + 12'($urandom_range(0, 63));
        r = $urandom_range(0, 7);
        it.write_data = (r == 0) ? 32'd0 : (r == 1) ? '1 : $urandom;
        // Small timer values so that the compare actually fires.
        if (it.address inside {CsrMtime, CsrMtimeh, CsrMtimecmp, CsrMtimecmph} &&
            $urandom_range(0, 1) == 1)
            it.write_data = $urandom_range(0, 8);
        it.privilege = 2'($urandom_range(0, 3));
        it.checked = ($urandom_range(0, 9) < 6);
        return it;
    endfunction

    // Sends one item, turning reads of never-written protection address
    // entries into writes, then perhaps leaves a gap.
    task automatic send_item(input t_in_item it);
        int idx;
        if (it.address >= CsrPmpAddrFirst && it.address <= CsrPmpAddrLast) begin
            idx = int'(it.address - CsrPmpAddrFirst);
            if (it.mode == ModeRead && !pmp_addr_written[idx]) it.mode = ModeWrite;
            if (it.mode == ModeWrite && (!it.checked || it.privilege == 2'd3))
                pmp_addr_written[idx] = 1'b1;
        end
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Waits until every result has come and the pipeline is empty.
    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mask(input logic [15:0] mask);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mask;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        repeat (count) send_item(random_access());
        drain();
    endtask

    // Stimulus
    initial begin
        cycle_count = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        gaps_on = 1'b0;
        pmp_addr_written = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: masks, aliasing, checks, timer and counters.
        write_mask(16'hFFFF);
        send_item(make_access(ModeRead, CsrMtvec, '0, 2'd3, 1'b1));
        send_item(make_access(ModeWrite, CsrMstatus, '1, 2'd3, 1'b1));
        send_item(make_access(ModeRead, CsrSstatus, '0, 2'd1, 1'b1));
        send_item(make_access(ModeWrite, CsrSstatus, '0, 2'd1, 1'b1));
        send_item(make_access(ModeRead, CsrMstatus, '0, 2'd3, 1'b1));
        send_item(make_access(ModeWrite, CsrMedeleg, '1, 2'd3, 1'b1));
        send_item(make_access(ModeRead, CsrMedeleg, '0, 2'd3, 1'b1));
        send_item(make_access(ModeWrite, CsrMip, '1, 2'd3, 1'b1));
        send_item(make_access(ModeWrite, CsrSepc, '1, 2'd1, 1'b1));
        send_item(make_access(ModeRead, CsrSepc, '0, 2'd2, 1'b1));
        send_item(make_access(ModeRead, CsrMstatus, '0, 2'd0, 1'b1));
        send_item(make_access(ModeWrite, CsrCycle, '1, 2'd3, 1'b1));
        send_item(make_access(ModeWrite, CsrCycle, '1, 2'd0, 1'b0));
        send_item(make_access(ModeRead, 12'hFFF, '0, 2'd3, 1'b0));
        send_item(make_access(ModeNone, CsrMstatus, '1, 2'd3, 1'b1));
        send_item(make_access(ModeWrite, CsrMtimecmp, 32'd2, 2'd3, 1'b1));
        send_item(make_access(ModeWrite, CsrMtimecmph, '0, 2'd3, 1'b1));
        repeat (3) send_item(make_access(ModeTick, '1, '1, 2'd0, 1'b1));
        send_item(make_access(ModeRead, CsrMip, '0, 2'd3, 1'b1));
        send_item(make_access(ModeRead, CsrTime, '0, 2'd0, 1'b0));
        send_item(make_access(ModeWrite, CsrMtimecmp, '1, 2'd3, 1'b1));
        send_item(make_access(ModeWrite, CsrPmpAddrLast, 32'hA5A5_5A5A, 2'd3, 1'b1));
        send_item(make_access(ModeRead, CsrPmpAddrLast, '0, 2'd3, 1'b1));
        send_item(make_access(ModeWrite, CsrMcycleh, '1, 2'd3, 1'b1));
        send_item(make_access(ModeRead, CsrCycleh, '0, 2'd0, 1'b0));
        drain();

        // Random phases over several mask settings, the last without gaps.
        gaps_on = 1'b1;
        write_mask(16'h0000);
        random_phase(300);
        write_mask(16'($urandom));
        random_phase(400);
        write_mask(EdelegReset);
        random_phase(250);
        gaps_on = 1'b0;
        random_phase(200);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
